@@ rtl/core/fpe_pkg.sv @@
// Shared types, constants and helpers of the frustum plane extractor.
package fpe_pkg;

   localparam int PLANE_COUNT   = 6;
   localparam int QUEUE_DEPTH   = 2;
   localparam int TERM_W        = 34;   // exact col4 +/- colN
   localparam int MAG_W         = 33;
   localparam int SQ_W          = 66;   // squares and their sum
   localparam int NUM_W         = 128;  // shifted dividend
   localparam int QUO_W         = 62;   // quotient bits below the overflow limit
   localparam int NORMAL_SHIFT  = 60;
   localparam int OFFSET_SHIFT  = 32;

   localparam logic [1:0] ROW_LAST = 2'd3;

   localparam logic [2:0] PLANE_LEFT   = 3'd0;
   localparam logic [2:0] PLANE_RIGHT  = 3'd1;
   localparam logic [2:0] PLANE_BOTTOM = 3'd2;
   localparam logic [2:0] PLANE_TOP    = 3'd3;
   localparam logic [2:0] PLANE_NEAR   = 3'd4;
   localparam logic [2:0] PLANE_FAR    = 3'd5;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] col1_value;
      logic signed [31:0] col2_value;
      logic signed [31:0] col3_value;
      logic signed [31:0] col4_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         plane_index;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic signed [31:0] plane_offset;
      logic               last_plane;
   } rsp_type;

   // element (row*4 + column) of the matrix
   typedef logic [15:0][31:0] mat_type;

   typedef struct packed {
      logic start;
      logic big_shift;   // 1: normal component, 0: offset term
      logic neg;
   } ratio_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } ratio_rsp_type;

   function automatic logic signed [TERM_W-1:0] plane_term(input mat_type m,
                                                           input logic [2:0] p,
                                                           input logic [1:0] r);
      logic signed [TERM_W-1:0] c1;
      logic signed [TERM_W-1:0] c2;
      logic signed [TERM_W-1:0] c3;
      logic signed [TERM_W-1:0] c4;
      logic signed [TERM_W-1:0] t;
      c1 = TERM_W'(signed'(m[{r, 2'd0}]));
      c2 = TERM_W'(signed'(m[{r, 2'd1}]));
      c3 = TERM_W'(signed'(m[{r, 2'd2}]));
      c4 = TERM_W'(signed'(m[{r, 2'd3}]));
      case (p)
         PLANE_LEFT:   t = c4 + c1;
         PLANE_RIGHT:  t = c4 - c1;
         PLANE_BOTTOM: t = c4 + c2;
         PLANE_TOP:    t = c4 - c2;
         PLANE_NEAR:   t = c3;
         default:      t = c4 - c3;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/core/fpe_front.sv @@
// Input side: keeps matrix rows and hands a full matrix on when row 3 lands.
module fpe_front import fpe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    push,
   output mat_type push_data,
   input  logic    full
);

   mat_type store_ff, store_in;
   logic    accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign push      = accept && (req_data.row_index == ROW_LAST);

   always_comb begin
      store_in = store_ff;
      if (accept) begin
         store_in[{req_data.row_index, 2'd0}] = req_data.col1_value;
         store_in[{req_data.row_index, 2'd1}] = req_data.col2_value;
         store_in[{req_data.row_index, 2'd2}] = req_data.col3_value;
         store_in[{req_data.row_index, 2'd3}] = req_data.col4_value;
      end
   end

   // rows 0..2 from the store, row 3 straight from the beat
   always_comb begin
      push_data     = store_ff;
      push_data[12] = req_data.col1_value;
      push_data[13] = req_data.col2_value;
      push_data[14] = req_data.col3_value;
      push_data[15] = req_data.col4_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
      end else begin
         store_ff <= store_in;
      end
   end

endmodule

@@ rtl/core/fpe_queue.sv @@
// Short matrix queue between the front and back halves.
module fpe_queue import fpe_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  mat_type push_data,
   output logic    full,
   input  logic    pop,
   output mat_type pop_data,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mat_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/fpe_ratio.sv @@
// Shared unit: isqrt(floor(square * 2^shift / sum)), signed and saturated.
module fpe_ratio import fpe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ratio_cmd_type   cmd,
   input  logic [SQ_W-1:0] square,
   input  logic [SQ_W-1:0] sum_sq,
   output ratio_rsp_type   rsp
);

   localparam logic [1:0] R_IDLE = 2'd0;
   localparam logic [1:0] R_DIV  = 2'd1;
   localparam logic [1:0] R_ROOT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [SQ_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [QUO_W-1:0] x_ff, x_in;
   logic [QUO_W-1:0] res_ff, res_in;
   logic [QUO_W-1:0] bit_ff, bit_in;
   logic             neg_ff, neg_in;
   logic             done_ff, done_in;
   logic [31:0]      value_ff, value_in;

   logic [NUM_W-1:0] num;
   logic [SQ_W-1:0]  num_hi;
   logic [SQ_W:0]    trial;
   logic [QUO_W-1:0] root_sum;
   logic [31:0]      root;

   assign num    = cmd.big_shift ? (NUM_W'(square) << NORMAL_SHIFT)
                                 : (NUM_W'(square) << OFFSET_SHIFT);
   assign num_hi = num[NUM_W-1:QUO_W];
   assign trial  = {rem_ff, low_ff[QUO_W-1]};
   assign root_sum = res_ff + bit_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      x_in     = x_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      root     = '0;
      case (state_ff)
         R_IDLE: begin
            if (cmd.start) begin
               neg_in = cmd.neg;
               if (num_hi >= sum_sq) begin
                  // quotient at or above 2^62
                  value_in = cmd.neg ? SAT_NEG : SAT_POS;
                  done_in  = 1'b1;
               end else begin
                  rem_in   = num_hi;
                  low_in   = num[QUO_W-1:0];
                  quo_in   = '0;
                  cnt_in   = 6'(QUO_W - 1);
                  state_in = R_DIV;
               end
            end
         end
         R_DIV: begin
            if (trial >= {1'b0, sum_sq}) begin
               rem_in = SQ_W'(trial - {1'b0, sum_sq});
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[SQ_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            low_in = {low_ff[QUO_W-2:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               x_in     = quo_in;
               res_in   = '0;
               bit_in   = QUO_W'(1) << (QUO_W - 2);
               cnt_in   = 6'(QUO_W / 2 - 1);
               state_in = R_ROOT;
            end
         end
         R_ROOT: begin
            if (x_ff >= root_sum) begin
               x_in   = x_ff - root_sum;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               root     = res_in[31:0];
               value_in = neg_ff ? (32'd0 - root) : root;
               done_in  = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      quo_ff   <= quo_in;
      x_ff     <= x_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

@@ rtl/core/fpe_back.sv @@
// Back side: builds the six planes of each queued matrix and drives results.
module fpe_back import fpe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    empty,
   input  mat_type pop_data,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   localparam logic [2:0] B_IDLE   = 3'd0;
   localparam logic [2:0] B_TERMS  = 3'd1;
   localparam logic [2:0] B_SQUARE = 3'd2;
   localparam logic [2:0] B_SUM    = 3'd3;
   localparam logic [2:0] B_GO     = 3'd4;
   localparam logic [2:0] B_WAIT   = 3'd5;
   localparam logic [2:0] B_EMIT   = 3'd6;

   logic [2:0]      state_ff, state_in;
   mat_type         mat_ff, mat_in;
   logic [2:0]      plane_ff, plane_in;
   logic [1:0]      k_ff, k_in;
   logic [3:0]      neg_ff, neg_in;
   logic [MAG_W-1:0] mag_ff [4];
   logic [MAG_W-1:0] mag_in [4];
   logic [SQ_W-1:0] sq_ff [4];
   logic [SQ_W-1:0] sq_in [4];
   logic [SQ_W-1:0] sum_ff, sum_in;
   logic [31:0]     res_ff [4];
   logic [31:0]     res_in [4];
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   ratio_cmd_type   cmd;
   ratio_rsp_type   rrsp;
   logic signed [TERM_W-1:0] term;

   fpe_ratio u_ratio (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .square (sq_ff[k_ff]),
      .sum_sq (sum_ff),
      .rsp    (rrsp)
   );

   always_comb begin
      state_in     = state_ff;
      mat_in       = mat_ff;
      plane_in     = plane_ff;
      k_in         = k_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      term         = '0;
      cmd.start     = 1'b0;
      cmd.big_shift = (k_ff != 2'd3);
      cmd.neg       = neg_ff[k_ff];
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               mat_in   = pop_data;
               plane_in = PLANE_LEFT;
               state_in = B_TERMS;
            end
         end
         B_TERMS: begin
            for (int i = 0; i < 4; i++) begin
               term      = plane_term(mat_ff, plane_ff, 2'(i));
               neg_in[i] = term[TERM_W-1];
               mag_in[i] = term[TERM_W-1] ? MAG_W'(-term) : term[MAG_W-1:0];
            end
            k_in     = '0;
            state_in = B_SQUARE;
         end
         B_SQUARE: begin
            sq_in[k_ff] = SQ_W'(mag_ff[k_ff]) * SQ_W'(mag_ff[k_ff]);
            k_in        = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = B_SUM;
            end
         end
         B_SUM: begin
            sum_in   = sq_ff[0] + sq_ff[1] + sq_ff[2];
            k_in     = '0;
            state_in = B_GO;
         end
         B_GO: begin
            if (sum_ff == '0) begin
               for (int i = 0; i < 4; i++) begin
                  res_in[i] = '0;
               end
               state_in = B_EMIT;
            end else begin
               cmd.start = 1'b1;
               state_in  = B_WAIT;
            end
         end
         B_WAIT: begin
            if (rrsp.done) begin
               res_in[k_ff] = rrsp.value;
               k_in         = k_ff + 2'd1;
               state_in     = (k_ff == 2'd3) ? B_EMIT : B_GO;
            end
         end
         B_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.plane_index  = plane_ff;
               rsp_in.normal_x     = res_ff[0];
               rsp_in.normal_y     = res_ff[1];
               rsp_in.normal_z     = res_ff[2];
               rsp_in.plane_offset = res_ff[3];
               rsp_in.last_plane   = (plane_ff == PLANE_FAR);
               rsp_valid_in        = 1'b1;
               if (plane_ff == PLANE_FAR) begin
                  state_in = B_IDLE;
               end else begin
                  plane_in = plane_ff + 3'd1;
                  state_in = B_TERMS;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mat_ff   <= mat_in;
      plane_ff <= plane_in;
      k_ff     <= k_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      sq_ff    <= sq_in;
      sum_ff   <= sum_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.plane_index <= PLANE_FAR)
      else $error("plane index out of range");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last_plane == (rsp_ff.plane_index == PLANE_FAR)))
      else $error("last_plane mismatch");

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      rrsp.done |-> state_ff == B_WAIT)
      else $error("ratio result with no request pending");

   a_normal_bound: assert property (@(posedge clock) disable iff (reset)
      (rrsp.done && k_ff != 2'd3) |->
         ($signed(rrsp.value) <= 32'sd1073741824 && $signed(rrsp.value) >= -32'sd1073741824))
      else $error("normal component above unit length");

endmodule

@@ rtl/core/frustum_plane_extractor.sv @@
// Top level of the frustum plane extractor.
//
// Usage: send a view-projection matrix one row per beat on the req_ channel
// (row_index plus four Q16.16 columns). Rows are kept; the beat for row 3
// snapshots the whole matrix into a small queue and six plane beats follow
// on the rsp_ channel: left, right, bottom, top, near, far, with last_plane
// set on far. Normals are Q2.30, plane_offset Q16.16 saturated; a plane with
// a zero-length normal comes out all zero.
// The back end processes one matrix at a time; each plane goes through
// setup and output (terms, four squares, sum, emit) plus, per component,
// one restoring divide of 62 steps and a 31-step square root in one
// shared unit (a saturated offset skips the divide and root, and a
// zero-length normal skips the unit). The queue holds QUEUE_DEPTH
// matrices; req_stall rises when full.
// Reset clears the row store to zero, empties the queue and drops any
// pending result. A stalled rsp_ beat holds; the back end waits on it and
// the front keeps taking rows until the queue fills.
module frustum_plane_extractor import fpe_pkg::*; #(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic    push, pop, full, empty;
   mat_type push_data, pop_data;

   // row store and trigger
   fpe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   // decouples row intake from plane computation
   fpe_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   // plane sequencer with shared divide / root unit
   fpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the frustum plane extractor.
module tb;
   import fpe_pkg::*;

   // ---------------------------------------------------------------------
   // Clock, reset, DUT hookup
   // ---------------------------------------------------------------------
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 1'b0;

   always #5 clock = ~clock;

   frustum_plane_extractor dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_data (req_data),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .rsp_stall(rsp_stall)
   );

   // The idle limit covers a matrix through the back end and the long
   // hold-off below with a wide margin.
   localparam int IDLE_LIMIT  = 40000;
   localparam int HOLD_CYCLES = 6000;
   localparam int DRAIN_WAIT  = 3000;
   localparam int RAND_ITEMS  = 250;

   localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
   localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [31:0] MONE_Q30 = 32'hC000_0000;

   // How a directed beat is checked: by the predictor, or against planes
   // typed in by hand (all-zero matrix, identity matrix).
   typedef enum logic [1:0] {CHK_PREDICT, CHK_ZERO, CHK_IDENTITY} chk_kind_type;

   typedef struct {
      req_type      beat;
      chk_kind_type chk;
   } stim_row_type;

   // ---------------------------------------------------------------------
   // Predictor state: private copy of the row store
   // ---------------------------------------------------------------------
   logic [31:0] row_mirror [16];
   rsp_type     plane_q [$];

   int  mismatches  = 0;
   int  stray_beats = 0;
   int  sent_items  = 0;
   bit  quiet       = 1'b0;   // no random idling on either side
   bit  hold_go     = 1'b0;   // ask the receiver for its long hold-off
   int  idle_count  = 0;

   // Plane term of one stored row (col3, or col4 +/- colN), exact at 34 bits
   function automatic logic signed [33:0] combo_term(input logic [2:0] p,
                                                     input int r);
      logic signed [33:0] c1, c2, c3, c4;
      c1 = 34'(signed'(row_mirror[r*4 + 0]));
      c2 = 34'(signed'(row_mirror[r*4 + 1]));
      c3 = 34'(signed'(row_mirror[r*4 + 2]));
      c4 = 34'(signed'(row_mirror[r*4 + 3]));
      case (p)
         PLANE_LEFT:   return c4 + c1;
         PLANE_RIGHT:  return c4 - c1;
         PLANE_BOTTOM: return c4 + c2;
         PLANE_TOP:    return c4 - c2;
         PLANE_NEAR:   return c3;
         default:      return c4 - c3;
      endcase
   endfunction

   function automatic logic [63:0] int_root(input logic [63:0] x);
      logic [63:0] res, b;
      res = '0;
      b   = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x   = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // sign(v) * floor(|v| * 2^(sh/2) / sqrt(s)), via root of the squared ratio
   function automatic logic [31:0] norm_ratio(input logic signed [33:0] v,
                                              input int sh,
                                              input logic [127:0] s);
      logic [127:0] mag, q;
      logic [63:0]  r;
      logic         neg;
      neg = v[33];
      mag = neg ? 128'(-v) : 128'(v);
      mag = mag & ((128'd1 << 34) - 1);
      q   = ((mag * mag) << sh) / s;
      if (q >= (128'd1 << 62))
         return neg ? SAT_NEG : SAT_POS;
      r = int_root(q[63:0]);
      return neg ? 32'(-r) : 32'(r);
   endfunction

   function automatic rsp_type plane_of(input logic [2:0] p);
      rsp_type o;
      logic signed [33:0] a, b, c, d;
      logic [127:0] s;
      a = combo_term(p, 0);
      b = combo_term(p, 1);
      c = combo_term(p, 2);
      d = combo_term(p, 3);
      s = 128'(a * a) + 128'(b * b) + 128'(c * c);
      o = '0;
      o.plane_index = p;
      o.last_plane  = (p == PLANE_FAR);
      if (s != 0) begin
         o.normal_x     = norm_ratio(a, NORMAL_SHIFT, s);
         o.normal_y     = norm_ratio(b, NORMAL_SHIFT, s);
         o.normal_z     = norm_ratio(c, NORMAL_SHIFT, s);
         o.plane_offset = norm_ratio(d, OFFSET_SHIFT, s);
      end
      return o;
   endfunction

   function automatic rsp_type typed_plane(input logic [2:0] p, input logic [31:0] nx,
                                           input logic [31:0] ny, input logic [31:0] nz,
                                           input logic [31:0] off);
      rsp_type o;
      o.plane_index  = p;
      o.normal_x     = nx;
      o.normal_y     = ny;
      o.normal_z     = nz;
      o.plane_offset = off;
      o.last_plane   = (p == PLANE_FAR);
      return o;
   endfunction

   // Update the mirror on an accepted beat; row 3 queues six planes.
   function automatic void absorb_row(input req_type r, input chk_kind_type chk);
      row_mirror[r.row_index*4 + 0] = r.col1_value;
      row_mirror[r.row_index*4 + 1] = r.col2_value;
      row_mirror[r.row_index*4 + 2] = r.col3_value;
      row_mirror[r.row_index*4 + 3] = r.col4_value;
      if (r.row_index != ROW_LAST) return;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         case (chk)
            CHK_ZERO:     plane_q.push_back(typed_plane(3'(p), 0, 0, 0, 0));
            CHK_IDENTITY: begin
               case (3'(p))
                  PLANE_LEFT:   plane_q.push_back(typed_plane(3'(p), ONE_Q30, 0, 0, ONE_Q16));
                  PLANE_RIGHT:  plane_q.push_back(typed_plane(3'(p), MONE_Q30, 0, 0, ONE_Q16));
                  PLANE_BOTTOM: plane_q.push_back(typed_plane(3'(p), 0, ONE_Q30, 0, ONE_Q16));
                  PLANE_TOP:    plane_q.push_back(typed_plane(3'(p), 0, MONE_Q30, 0, ONE_Q16));
                  PLANE_NEAR:   plane_q.push_back(typed_plane(3'(p), 0, 0, ONE_Q30, 0));
                  default:      plane_q.push_back(typed_plane(3'(p), 0, 0, MONE_Q30, ONE_Q16));
               endcase
            end
            default:      plane_q.push_back(plane_of(3'(p)));
         endcase
      end
   endfunction

   // ---------------------------------------------------------------------
   // Sender: one beat per call; gaps only where the channel is free
   // ---------------------------------------------------------------------
   task automatic send_row(input req_type r, input chk_kind_type chk);
      while (!quiet && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      absorb_row(r, chk);
      sent_items++;
      if (sent_items == 60) hold_go = 1'b1;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
         2: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18)) << 8;
         3: begin
            case ($urandom_range(0, 4))
               0: return SAT_NEG;
               1: return SAT_POS;
               2: return 32'hFFFF_FFFF;
               3: return 32'd1;
               default: return 32'd0;
            endcase
         end
         default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18)) << 12;
      endcase
   endfunction

   function automatic req_type rand_row(input logic [1:0] row);
      req_type r;
      r.row_index  = row;
      r.col1_value = pick_value();
      r.col2_value = pick_value();
      r.col3_value = pick_value();
      r.col4_value = pick_value();
      return r;
   endfunction

   // Directed table: empty store, identity, offset saturation both ways,
   // extreme elements, zero-length normals, a row written twice.
   stim_row_type directed [] = '{
      '{'{ROW_LAST, 0, 0, 0, 0},                              CHK_ZERO},
      '{'{2'd0, ONE_Q16, 0, 0, 0},                            CHK_PREDICT},
      '{'{2'd1, 0, ONE_Q16, 0, 0},                            CHK_PREDICT},
      '{'{2'd2, 0, 0, ONE_Q16, 0},                            CHK_PREDICT},
      '{'{ROW_LAST, 0, 0, 0, ONE_Q16},                        CHK_IDENTITY},
      '{'{2'd0, 1, 0, 0, 0},                                  CHK_PREDICT},
      '{'{2'd1, 0, 1, 0, 0},                                  CHK_PREDICT},
      '{'{2'd2, 0, 0, 1, 0},                                  CHK_PREDICT},
      '{'{ROW_LAST, 0, 0, 0, SAT_POS},                        CHK_PREDICT},
      '{'{ROW_LAST, 0, 0, 0, SAT_NEG},                        CHK_PREDICT},
      '{'{2'd0, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG},          CHK_PREDICT},
      '{'{2'd1, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG},          CHK_PREDICT},
      '{'{2'd2, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG},          CHK_PREDICT},
      '{'{ROW_LAST, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG},      CHK_PREDICT},
      '{'{2'd0, SAT_POS, SAT_POS, SAT_POS, SAT_POS},          CHK_PREDICT},
      '{'{2'd1, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG},          CHK_PREDICT},
      '{'{2'd2, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS},          CHK_PREDICT},
      '{'{ROW_LAST, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS},      CHK_PREDICT},
      '{'{2'd2, 32'h1234_5678, 32'h0F0F_0F0F, 3, 7},          CHK_PREDICT},
      '{'{2'd2, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_0000, 32'h0002_0000},
        CHK_PREDICT},
      '{'{ROW_LAST, 32'h0003_0000, 32'hFFFF_FFFF, 0, 32'h0001_8000},
        CHK_PREDICT}
   };

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int rand_sent;
      foreach (row_mirror[i]) row_mirror[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) send_row(directed[i].beat, directed[i].chk);

      // Mostly complete matrices in row order; the rest are stray rows that
      // leave the store partly stale.
      rand_sent = 0;
      while (rand_sent < RAND_ITEMS) begin
         quiet = (rand_sent >= 120 && rand_sent < 170);
         if ($urandom_range(0, 9) < 8) begin
            for (int r = 0; r < 4; r++) send_row(rand_row(2'(r)), CHK_PREDICT);
            rand_sent += 4;
         end else begin
            send_row(rand_row(2'($urandom_range(0, 3))), CHK_PREDICT);
            rand_sent++;
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (plane_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0 && stray_beats == 0 && plane_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver stall: random idling, one long hold-off to back up the queue
   // ---------------------------------------------------------------------
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 17);
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: field by field against the oldest expected plane
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (plane_q.size() == 0) begin
            stray_beats++;
            if (mismatches + stray_beats <= 10)
               $display("unexpected rsp beat: %p", rsp_data);
         end else begin
            want = plane_q.pop_front();
            if (rsp_data.plane_index  !== want.plane_index  ||
                rsp_data.normal_x     !== want.normal_x     ||
                rsp_data.normal_y     !== want.normal_y     ||
                rsp_data.normal_z     !== want.normal_z     ||
                rsp_data.plane_offset !== want.plane_offset ||
                rsp_data.last_plane   !== want.last_plane) begin
               mismatches++;
               if (mismatches + stray_beats <= 10) begin
                  $display("plane mismatch: index exp %0d got %0d, last exp %0b got %0b",
                           want.plane_index, rsp_data.plane_index,
                           want.last_plane, rsp_data.last_plane);
                  $display("  nx exp %h got %h  ny exp %h got %h",
                           want.normal_x, rsp_data.normal_x,
                           want.normal_y, rsp_data.normal_y);
                  $display("  nz exp %h got %h  d exp %h got %h",
                           want.normal_z, rsp_data.normal_z,
                           want.plane_offset, rsp_data.plane_offset);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: cycles without any beat on either channel
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

endmodule

@@ files.f @@
rtl/core/fpe_pkg.sv
rtl/core/fpe_front.sv
rtl/core/fpe_queue.sv
rtl/core/fpe_ratio.sv
rtl/core/fpe_back.sv
rtl/core/frustum_plane_extractor.sv
sim/tb.sv
